// ===== sv/assert_macros.svh =====
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser check failed");

// next-cycle implication, checked outside reset
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

// ===== sv/mtep_pkg.sv =====
// types, codes and constants of the midi track event parser
package mtep_pkg;

  localparam int TEMPO_W = 24;
  localparam int QUOT_W  = 26;

  // dividend of the bpm division and the number of quotient bits it needs
  localparam logic [QUOT_W-1:0] USEC_PER_MIN = 26'd60000000;
  localparam logic [4:0]        DIV_STEPS    = 5'd26;

  // result kinds
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_PROGRAM  = 2'd2;
  localparam logic [1:0] KIND_TEMPO    = 2'd3;

  // status bytes and status classes
  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] STATUS_ESC   = 8'hF7;
  localparam logic [7:0] TEMPO_META   = 8'h51;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CONTROL   = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PITCH     = 4'hE;

  // byte parsing phases
  typedef enum logic [8:0] {
    PH_DELTA     = 9'b000000001,
    PH_STATUS    = 9'b000000010,
    PH_DATA1     = 9'b000000100,
    PH_DATA2     = 9'b000001000,
    PH_META_TYPE = 9'b000010000,
    PH_META_LEN  = 9'b000100000,
    PH_META_DATA = 9'b001000000,
    PH_SYS_LEN   = 9'b010000000,
    PH_SYS_DATA  = 9'b100000000
  } phase_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [TEMPO_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/mtep_div.sv =====
// restoring divider, one quotient bit per cycle, for 60000000 / tempo
module mtep_div (
  input  logic              clk,
  input  logic              rst,
  input  mtep_pkg::div_req_t req,
  output mtep_pkg::div_rsp_t rsp
);
  import mtep_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } div_state_t;

  div_state_t          state;
  logic [4:0]          cnt;
  logic [4:0]          bit_idx;
  logic [TEMPO_W-1:0]  divisor;
  logic [TEMPO_W-1:0]  rem;
  logic [QUOT_W-1:0]   quot;
  logic [TEMPO_W:0]    trial;
  logic [TEMPO_W:0]    diff;
  logic                qbit;

  // one trial subtraction per cycle
  always_comb begin
    bit_idx = cnt - 5'd1;
    trial   = {rem, USEC_PER_MIN[bit_idx]};
    diff    = trial - {1'b0, divisor};
    qbit    = (trial >= {1'b0, divisor});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_RUN;
            cnt   <= DIV_STEPS;
          end
        end
        S_RUN: begin
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quot    <= '0;
    end else if (state == S_RUN) begin
      rem  <= qbit ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];
      quot <= {quot[QUOT_W-2:0], qbit};
    end
  end

  assign rsp.done = (state == S_DONE);
  assign rsp.quot = quot;

  `include "assert_macros.svh"

  // the step counter never runs out while iterating
  `CHECK_NOW(a_run_cnt, state == S_RUN, cnt != 5'd0)
  // done is a single-cycle pulse
  `CHECK_NEXT(a_done_pulse, state == S_DONE, state == S_IDLE)

endmodule

// ===== sv/midi_track_event_parser.sv =====
// midi track parser: byte stream in, note, program and tempo events out
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready   | data_byte, last_byte
//  output  | out       | out_valid / out_ready | kind, channel, note, velocity, abs_time,
//          |           |                       | tempo_usec, bpm
//
// one byte per cycle outside a division, while the output register is free or being drained.
// a tempo event with non-zero tempo runs the restoring divider:
// in_ready stays low until the divider is done and the tempo result is loaded.
// rst is synchronous; all parser state returns to "expecting delta time".
// a result waits in the output register; a new byte is taken in the cycle it drains.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [3:0]  channel,
  output logic [7:0]  note,
  output logic [7:0]  velocity,
  output logic [31:0] abs_time,
  output logic [23:0] tempo_usec,
  output logic [25:0] bpm
);
  import mtep_pkg::*;

  typedef enum logic [1:0] {
    T_PARSE = 2'b01,
    T_DIV   = 2'b10
  } top_state_t;

  top_state_t top_state;

  // parser state
  phase_t      phase, phase_next;
  logic [31:0] delta_acc, delta_acc_next;
  logic [31:0] time_acc, time_acc_next;
  logic [7:0]  rs_byte, rs_byte_next;
  logic        rs_valid, rs_valid_next;
  logic [7:0]  first_data, first_data_next;
  logic [31:0] skip_cnt, skip_cnt_next;
  logic [7:0]  meta_kind, meta_kind_next;
  logic [23:0] tempo_acc, tempo_acc_next;
  logic [1:0]  data_cnt, data_cnt_next;

  // per-beat working values
  logic        accept;
  logic        emit;
  logic        launch;
  logic        do_delta;
  logic        do_first;
  logic [3:0]  hi;
  logic [31:0] d_shift;
  logic [31:0] l_shift;
  logic [31:0] skip_dec;
  logic [23:0] t_shift;
  logic [1:0]  kind_n;
  logic [3:0]  ch_n;
  logic [7:0]  note_n;
  logic [7:0]  vel_n;
  logic [23:0] tempo_n;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready = (top_state == T_PARSE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // byte decoder
  always_comb begin
    phase_next      = phase;
    delta_acc_next  = delta_acc;
    time_acc_next   = time_acc;
    rs_byte_next    = rs_byte;
    rs_valid_next   = rs_valid;
    first_data_next = first_data;
    skip_cnt_next   = skip_cnt;
    meta_kind_next  = meta_kind;
    tempo_acc_next  = tempo_acc;
    data_cnt_next   = data_cnt;
    emit            = 1'b0;
    do_delta        = 1'b0;
    do_first        = 1'b0;
    kind_n          = KIND_NOTE_ON;
    ch_n            = '0;
    note_n          = '0;
    vel_n           = '0;
    tempo_n         = '0;
    hi              = rs_byte[7:4];
    d_shift         = {delta_acc[24:0], data_byte[6:0]};
    l_shift         = {skip_cnt[24:0], data_byte[6:0]};
    skip_dec        = skip_cnt - 32'd1;
    t_shift         = {tempo_acc[15:0], data_byte};

    case (phase)
      PH_STATUS: begin
        if (data_byte == STATUS_META) begin
          rs_valid_next = 1'b0;
          rs_byte_next  = '0;
          phase_next    = PH_META_TYPE;
        end else if (data_byte == STATUS_SYSEX || data_byte == STATUS_ESC) begin
          rs_valid_next = 1'b0;
          rs_byte_next  = '0;
          skip_cnt_next = '0;
          phase_next    = PH_SYS_LEN;
        end else if (data_byte[7]) begin
          rs_byte_next  = data_byte;
          rs_valid_next = 1'b1;
          phase_next    = PH_DATA1;
        end else if (rs_valid) begin
          do_first = 1'b1;
        end else begin
          do_delta = 1'b1;
        end
      end
      PH_DATA1: do_first = 1'b1;
      PH_DATA2: begin
        if (hi == HI_NOTE_ON) begin
          emit   = 1'b1;
          kind_n = (data_byte != 8'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
          ch_n   = rs_byte[3:0];
          note_n = first_data;
          vel_n  = data_byte;
        end else if (hi == HI_NOTE_OFF) begin
          emit   = 1'b1;
          kind_n = KIND_NOTE_OFF;
          ch_n   = rs_byte[3:0];
          note_n = first_data;
        end
        phase_next = PH_DELTA;
      end
      PH_META_TYPE: begin
        meta_kind_next = data_byte;
        skip_cnt_next  = '0;
        tempo_acc_next = '0;
        data_cnt_next  = '0;
        phase_next     = PH_META_LEN;
      end
      PH_META_LEN, PH_SYS_LEN: begin
        skip_cnt_next = l_shift;
        if (!data_byte[7]) begin
          if (l_shift == 32'd0) begin
            phase_next = PH_DELTA;
          end else begin
            phase_next = (phase == PH_META_LEN) ? PH_META_DATA : PH_SYS_DATA;
          end
        end
      end
      PH_META_DATA: begin
        if (meta_kind == TEMPO_META && data_cnt != 2'd3) begin
          tempo_acc_next = t_shift;
          data_cnt_next  = data_cnt + 2'd1;
          if (data_cnt == 2'd2) begin
            emit    = 1'b1;
            kind_n  = KIND_TEMPO;
            tempo_n = t_shift;
          end
        end
        skip_cnt_next = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_next = PH_DELTA;
        end
      end
      PH_SYS_DATA: begin
        skip_cnt_next = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_next = PH_DELTA;
        end
      end
      default: do_delta = 1'b1;
    endcase

    // variable-length delta time
    if (do_delta) begin
      if (!data_byte[7]) begin
        time_acc_next  = time_acc + d_shift;
        delta_acc_next = '0;
        phase_next     = PH_STATUS;
      end else begin
        delta_acc_next = d_shift;
        phase_next     = PH_DELTA;
      end
    end

    // first data byte of a channel event
    if (do_first) begin
      first_data_next = data_byte;
      if (hi inside {HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_PITCH}) begin
        phase_next = PH_DATA2;
      end else begin
        phase_next = PH_DELTA;
        if (hi == HI_PROGRAM) begin
          emit   = 1'b1;
          kind_n = KIND_PROGRAM;
          ch_n   = rs_byte[3:0];
          note_n = {1'b0, data_byte[6:0]};
        end
      end
    end

    // end of track clears the parser
    if (last_byte) begin
      phase_next      = PH_DELTA;
      delta_acc_next  = '0;
      time_acc_next   = '0;
      rs_byte_next    = '0;
      rs_valid_next   = 1'b0;
      first_data_next = '0;
      skip_cnt_next   = '0;
      meta_kind_next  = '0;
      tempo_acc_next  = '0;
      data_cnt_next   = '0;
    end
  end

  // a non-zero tempo needs the divider before the result can go out
  assign launch = accept && emit && (kind_n == KIND_TEMPO) && (tempo_n != 24'd0);

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DELTA;
      delta_acc  <= '0;
      time_acc   <= '0;
      rs_byte    <= '0;
      rs_valid   <= 1'b0;
      first_data <= '0;
      skip_cnt   <= '0;
      meta_kind  <= '0;
      tempo_acc  <= '0;
      data_cnt   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      delta_acc  <= delta_acc_next;
      time_acc   <= time_acc_next;
      rs_byte    <= rs_byte_next;
      rs_valid   <= rs_valid_next;
      first_data <= first_data_next;
      skip_cnt   <= skip_cnt_next;
      meta_kind  <= meta_kind_next;
      tempo_acc  <= tempo_acc_next;
      data_cnt   <= data_cnt_next;
    end
  end

  // sequencer around the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      top_state <= T_PARSE;
    end else begin
      case (top_state)
        T_PARSE: if (launch) top_state <= T_DIV;
        T_DIV:   if (div_rsp.done) top_state <= T_PARSE;
        default: top_state <= T_PARSE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if ((accept && emit && !launch) || (top_state == T_DIV && div_rsp.done)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind       <= kind_n;
      channel    <= ch_n;
      note       <= note_n;
      velocity   <= vel_n;
      abs_time   <= time_acc;
      tempo_usec <= tempo_n;
      bpm        <= '0;
    end else if (top_state == T_DIV && div_rsp.done) begin
      bpm <= div_rsp.quot;
    end
  end

  assign div_req.start   = launch;
  assign div_req.divisor = tempo_n;

  mtep_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `include "assert_macros.svh"

  // the divider only finishes while the sequencer waits for it
  `CHECK_NOW(a_done_in_div, div_rsp.done, top_state == T_DIV)
  // the output register is empty for the whole division
  `CHECK_NOW(a_empty_in_div, top_state == T_DIV, !out_valid)
  // a tempo launch holds off both the output and further bytes
  `CHECK_NEXT(a_launch_div, launch, top_state == T_DIV && !out_valid && !in_ready)

endmodule
